/* hdl/rmq_pkg.sv */
package rmq_pkg;

    localparam int FIELD_W = 18;
    // sums and differences of two matrix elements
    localparam int NUM_W = FIELD_W + 1;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [NUM_W-1:0] num_t;

    // component built from the root
    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    typedef struct packed {
        logic neg;
        logic sat;
        logic zero;
    } div_flag_t;

endpackage

/* hdl/rmq_sqrt.sv */
module rmq_sqrt #(
    parameter int VW = 36,
    parameter int RW = 18
) (
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] rad,
    output logic [RW-1:0] root
);
    import rmq_pkg::*;

    localparam int PW  = 2 * RW;
    localparam int REW = RW + 3;

    // one result bit per stage
    logic [PW-1:0]  rad_reg  [RW];
    logic [REW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [PW-1:0]  rad_next [RW];
    logic [REW-1:0] rem_next [RW];
    logic [RW-1:0]  root_next[RW];
    logic [PW-1:0]  rad_prev [RW];
    logic [REW-1:0] rem_prev [RW];
    logic [RW-1:0]  root_prev[RW];

    always_comb
    begin
        rad_prev[0]  = PW'(rad);
        rem_prev[0]  = '0;
        root_prev[0] = '0;
        for (int j = 1; j < RW; j++)
        begin
            rad_prev[j]  = rad_reg[j-1];
            rem_prev[j]  = rem_reg[j-1];
            root_prev[j] = root_reg[j-1];
        end
    end

    always_comb
    begin
        logic [REW-1:0] rem_sh;
        logic [REW-1:0] test;
        for (int j = 0; j < RW; j++)
        begin
            rem_sh = {rem_prev[j][REW-3:0], rad_prev[j][PW-1 -: 2]};
            test   = REW'({root_prev[j], 2'b01});
            rad_next[j] = rad_prev[j] << 2;
            if (rem_sh >= test)
            begin
                rem_next[j]  = rem_sh - test;
                root_next[j] = {root_prev[j][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = rem_sh;
                root_next[j] = {root_prev[j][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < RW; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* hdl/rmq_div.sv */
module rmq_div #(
    parameter int RW = 18,
    parameter int QW = 17
) (
    input  logic               clk,
    input  logic               en,
    input  rmq_pkg::num_t      num,
    input  logic [RW-1:0]      root,
    output logic signed [QW:0] quo
);
    import rmq_pkg::*;

    localparam int DW = RW + 2;
    localparam int CW = ((NUM_W > DW) ? NUM_W : DW) + 1;
    localparam logic [QW-1:0] ONE_Q = {1'b1, {(QW-1){1'b0}}};

    logic [NUM_W-1:0] mag;
    div_flag_t        flag_in;

    logic [DW-1:0] e_p_reg;
    logic [RW:0]   e_d_reg;
    div_flag_t     e_flag_reg;

    logic [DW-1:0] p_reg   [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [RW:0]   d_reg   [QW];
    div_flag_t     flag_reg[QW];
    logic [DW-1:0] p_prev  [QW];
    logic [QW-1:0] q_prev  [QW];
    logic [RW:0]   d_prev  [QW];
    div_flag_t     flag_prev[QW];
    logic [DW-1:0] p_next  [QW];
    logic [QW-1:0] q_next  [QW];

    logic [QW-1:0] q_mag;

    // magnitude, and a quotient of two or more saturates at once
    always_comb
    begin
        flag_in.neg  = num[NUM_W-1];
        mag          = flag_in.neg ? NUM_W'(-num) : NUM_W'(num);
        flag_in.zero = (mag == '0);
        flag_in.sat  = !flag_in.zero && (CW'(mag) >= CW'({root, 2'b00}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_p_reg    <= DW'(mag);
            e_d_reg    <= {root, 1'b0};
            e_flag_reg <= flag_in;
        end
    end

    always_comb
    begin
        p_prev[0]    = e_p_reg;
        q_prev[0]    = '0;
        d_prev[0]    = e_d_reg;
        flag_prev[0] = e_flag_reg;
        for (int j = 1; j < QW; j++)
        begin
            p_prev[j]    = p_reg[j-1];
            q_prev[j]    = q_reg[j-1];
            d_prev[j]    = d_reg[j-1];
            flag_prev[j] = flag_reg[j-1];
        end
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        logic [DW-1:0] pp;
        logic [DW-1:0] dd;
        for (int j = 0; j < QW; j++)
        begin
            pp = (j == 0) ? p_prev[j] : (p_prev[j] << 1);
            dd = DW'(d_prev[j]);
            if (pp >= dd)
            begin
                p_next[j] = pp - dd;
                q_next[j] = {q_prev[j][QW-2:0], 1'b1};
            end
            else
            begin
                p_next[j] = pp;
                q_next[j] = {q_prev[j][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                p_reg[j]    <= p_next[j];
                q_reg[j]    <= q_next[j];
                d_reg[j]    <= d_prev[j];
                flag_reg[j] <= flag_prev[j];
            end
        end
    end

    always_comb
    begin
        if (flag_reg[QW-1].zero)
            q_mag = '0;
        else if (flag_reg[QW-1].sat || (q_reg[QW-1] > ONE_Q))
            q_mag = ONE_Q;
        else
            q_mag = q_reg[QW-1];
        quo = flag_reg[QW-1].neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

endmodule

/* hdl/rotation_matrix_to_quaternion.sv */
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------
// input   | in_valid / in_stall  | m00 m01 m02 m10 m11 m12 m20 m21 m22
// output  | out_valid / out_stall| quat_w quat_x quat_y quat_z
//
// One transaction per cycle in steady state while the output is not stalled.
// Data passes a select stage, RW square root stages (RW = root
// width, 18 at defaults), FRAC_BITS + 2 divider stages and the output
// register. Reset clears only the valid bits. A stalled output holding a
// result freezes every stage; in_stall follows it in the same cycle.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rmq_pkg::field_t m00,
    input  rmq_pkg::field_t m01,
    input  rmq_pkg::field_t m02,
    input  rmq_pkg::field_t m10,
    input  rmq_pkg::field_t m11,
    input  rmq_pkg::field_t m12,
    input  rmq_pkg::field_t m20,
    input  rmq_pkg::field_t m21,
    input  rmq_pkg::field_t m22,
    output logic            out_valid,
    input  logic            out_stall,
    output rmq_pkg::field_t quat_w,
    output rmq_pkg::field_t quat_x,
    output rmq_pkg::field_t quat_y,
    output rmq_pkg::field_t quat_z
);
    import rmq_pkg::*;

    // radicand width, its root, quotient magnitude width
    localparam int TW = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 3;
    localparam int VW = TW - 1 + FRAC_BITS;
    localparam int RW = (VW + 1) / 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = RW + QW;
    localparam int L  = RW + QW + 2;

    localparam logic signed [TW-1:0] ONE_T = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [QW-1:0] ONE_Q = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW:0] ONE_S = {2'b01, {(QW-1){1'b0}}};

    logic en;
    logic [L-1:0] vld_reg;
    logic out_valid_reg;

    // global advance: stall only when a finished result is held
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    //------------------------------------------------------------------
    // Select stage: branch, radicand and off-diagonal numerators
    //------------------------------------------------------------------
    logic signed [TW-1:0] e00, e11, e22, trace;
    logic signed [TW-1:0] t_sel;
    sel_t                 sel_sel;
    num_t                 num_sel[4];
    num_t                 d_x, d_y, d_z, s_xy, s_xz, s_yz;

    assign e00   = TW'(m00);
    assign e11   = TW'(m11);
    assign e22   = TW'(m22);
    assign trace = e00 + e11 + e22;
    assign d_x   = NUM_W'(m21) - NUM_W'(m12);
    assign d_y   = NUM_W'(m02) - NUM_W'(m20);
    assign d_z   = NUM_W'(m10) - NUM_W'(m01);
    assign s_xy  = NUM_W'(m01) + NUM_W'(m10);
    assign s_xz  = NUM_W'(m02) + NUM_W'(m20);
    assign s_yz  = NUM_W'(m12) + NUM_W'(m21);

    always_comb
    begin
        if (trace > 0)
        begin
            sel_sel = SEL_W;
            t_sel   = trace + ONE_T;
            num_sel = '{'0, d_x, d_y, d_z};
        end
        else if ((m00 > m11) && (m00 > m22))
        begin
            sel_sel = SEL_X;
            t_sel   = ONE_T + e00 - e11 - e22;
            num_sel = '{d_x, '0, s_xy, s_xz};
        end
        else if (m11 > m22)
        begin
            sel_sel = SEL_Y;
            t_sel   = ONE_T + e11 - e00 - e22;
            num_sel = '{d_y, s_xy, '0, s_yz};
        end
        else
        begin
            sel_sel = SEL_Z;
            t_sel   = ONE_T + e22 - e00 - e11;
            num_sel = '{d_z, s_xz, s_yz, '0};
        end
    end

    logic signed [TW-1:0] a_t_reg;
    sel_t                 a_sel_reg;
    num_t                 a_num_reg[4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_t_reg   <= t_sel;
            a_sel_reg <= sel_sel;
            a_num_reg <= num_sel;
        end
    end

    //------------------------------------------------------------------
    // Square root of T * 2^FRAC_BITS; a negative radicand gives zero
    //------------------------------------------------------------------
    logic [VW-1:0] rad;
    logic [RW-1:0] root;

    assign rad = (a_t_reg > 0) ? {a_t_reg[TW-2:0], {FRAC_BITS{1'b0}}} : '0;

    rmq_sqrt #(
        .VW (VW),
        .RW (RW)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad),
        .root (root)
    );

    sel_t sq_sel_reg[RW];
    num_t sq_num_reg[RW][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_sel_reg[0] <= a_sel_reg;
            sq_num_reg[0] <= a_num_reg;
            for (int j = 1; j < RW; j++)
            begin
                sq_sel_reg[j] <= sq_sel_reg[j-1];
                sq_num_reg[j] <= sq_num_reg[j-1];
            end
        end
    end

    //------------------------------------------------------------------
    // Four divider lanes; the lane of the root component sees a zero
    // numerator and is replaced by the clamped half root at the end
    //------------------------------------------------------------------
    logic signed [QW:0] quo[4];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        rmq_div #(
            .RW (RW),
            .QW (QW)
        ) u_div (
            .clk  (clk),
            .en   (en),
            .num  (sq_num_reg[RW-1][i]),
            .root (root),
            .quo  (quo[i])
        );
    end

    logic [RW-2:0] half;
    logic [QW-1:0] half_c;

    assign half   = root[RW-1:1];
    assign half_c = (CW'(half) > CW'(ONE_Q)) ? ONE_Q : QW'(half);

    sel_t          dv_sel_reg [QW+1];
    logic [QW-1:0] dv_half_reg[QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_sel_reg[0]  <= sq_sel_reg[RW-1];
            dv_half_reg[0] <= half_c;
            for (int j = 1; j <= QW; j++)
            begin
                dv_sel_reg[j]  <= dv_sel_reg[j-1];
                dv_half_reg[j] <= dv_half_reg[j-1];
            end
        end
    end

    logic signed [QW:0] lane_val[4];
    logic signed [QW:0] half_s;

    assign half_s = $signed({1'b0, dv_half_reg[QW]});

    always_comb
    begin
        lane_val[0] = (dv_sel_reg[QW] == SEL_W) ? half_s : quo[0];
        lane_val[1] = (dv_sel_reg[QW] == SEL_X) ? half_s : quo[1];
        lane_val[2] = (dv_sel_reg[QW] == SEL_Y) ? half_s : quo[2];
        lane_val[3] = (dv_sel_reg[QW] == SEL_Z) ? half_s : quo[3];
    end

    //------------------------------------------------------------------
    // Valid bits and output register
    //------------------------------------------------------------------
    field_t quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[L-2:0], in_valid};
            out_valid_reg <= vld_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_w_reg <= FIELD_W'(lane_val[0]);
            quat_x_reg <= FIELD_W'(lane_val[1]);
            quat_y_reg <= FIELD_W'(lane_val[2]);
            quat_z_reg <= FIELD_W'(lane_val[3]);
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_w    = quat_w_reg;
    assign quat_x    = quat_x_reg;
    assign quat_y    = quat_y_reg;
    assign quat_z    = quat_z_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // positive trace means T > ONE, so the half root cannot be zero
    a_w_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[L-1] && (dv_sel_reg[QW] == SEL_W)) |-> (dv_half_reg[QW] != '0))
        else $error("w branch reached the output with a zero root");

    a_lane_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[L-1] |-> ((lane_val[0] <= ONE_S) && (lane_val[0] >= -ONE_S)
                       && (lane_val[1] <= ONE_S) && (lane_val[1] >= -ONE_S)
                       && (lane_val[2] <= ONE_S) && (lane_val[2] >= -ONE_S)
                       && (lane_val[3] <= ONE_S) && (lane_val[3] >= -ONE_S)))
        else $error("quaternion component beyond +/-ONE");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[L-1]) |=> out_valid_reg)
        else $error("result lost between last stage and output");

endmodule
